// File: design/cdad_pkg.sv
package cdad_pkg;

	localparam int ADD_WIDTH  = 16;
	localparam int YEAR_LIMIT = 9999;

	localparam int DAY_W   = 5;
	localparam int MON_W   = 4;
	localparam int YEAR_W  = 14;
	localparam int DOY_W   = 9;
	localparam int DADD_W  = 16;
	localparam int LYEAR_W = 16;
	localparam int SUM_W   = DADD_W + 1;
	localparam int Y25_W   = 5;
	localparam int KCNT_W  = 4;

	localparam logic [YEAR_W-1:0] RESET_YEAR = YEAR_W'(2000);
	localparam logic [Y25_W-1:0]  RESET_Y25  = Y25_W'(2000 % 25);
	localparam logic [Y25_W-1:0]  MOD25      = Y25_W'(25);
	// 25 << 9 is the largest multiple of this form below 2^14
	localparam logic [KCNT_W-1:0] MOD_TOP    = KCNT_W'(9);

	localparam logic [DADD_W-1:0] ADD_MASK =
		(ADD_WIDTH >= DADD_W) ? {DADD_W{1'b1}} : DADD_W'((32'd1 << ADD_WIDTH) - 32'd1);

	// year mod 400 == 0 iff mod 16 and mod 25 are zero; mod 100 likewise with 4
	function automatic logic leap_of(input logic [YEAR_W-1:0] yr, input logic [Y25_W-1:0] y25);
		return (yr[1:0] == 2'd0) && ((y25 != '0) || (yr[3:0] == 4'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon, input logic leap);
		logic [DAY_W-1:0] len;
		case (mon) inside
			4'd2: len = leap ? DAY_W'(29) : DAY_W'(28);
			4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
			default: len = DAY_W'(31);
		endcase
		return len;
	endfunction

	// days of all earlier months in a common year
	function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] mon);
		logic [DOY_W-1:0] c;
		unique case (mon)
			4'd2:  c = DOY_W'(31);
			4'd3:  c = DOY_W'(59);
			4'd4:  c = DOY_W'(90);
			4'd5:  c = DOY_W'(120);
			4'd6:  c = DOY_W'(151);
			4'd7:  c = DOY_W'(181);
			4'd8:  c = DOY_W'(212);
			4'd9:  c = DOY_W'(243);
			4'd10: c = DOY_W'(273);
			4'd11: c = DOY_W'(304);
			4'd12: c = DOY_W'(334);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// File: design/cdad_in_if.sv
interface cdad_in_if;
	import cdad_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [5:0]                new_day;
	logic [3:0]                new_month;
	logic signed [LYEAR_W-1:0] new_year;
	logic [DADD_W-1:0]         days_to_add;

	modport source (output valid, op, new_day, new_month, new_year, days_to_add, input ready);
	modport sink (input valid, op, new_day, new_month, new_year, days_to_add, output ready);
endinterface

// File: design/cdad_out_if.sv
interface cdad_out_if;
	import cdad_pkg::*;

	logic              valid;
	logic              ready;
	logic [DAY_W-1:0]  out_day;
	logic [MON_W-1:0]  out_month;
	logic [YEAR_W-1:0] out_year;
	logic [DOY_W-1:0]  day_of_year;
	logic [DOY_W-1:0]  days_remaining;
	logic              is_leap;
	logic              overflow;

	modport source (output valid, out_day, out_month, out_year, day_of_year, days_remaining,
		is_leap, overflow, input ready);
	modport sink (input valid, out_day, out_month, out_year, day_of_year, days_remaining,
		is_leap, overflow, output ready);
endinterface

// File: design/cdad_report.sv
module cdad_report (
	input  logic [cdad_pkg::DAY_W-1:0] day,
	input  logic [cdad_pkg::MON_W-1:0] month,
	input  logic                       leap,
	output logic [cdad_pkg::DOY_W-1:0] doy,
	output logic [cdad_pkg::DOY_W-1:0] remaining
);
	import cdad_pkg::*;

	logic [DOY_W-1:0] total;

	always_comb begin
		doy = DOY_W'(day) + cum_days(month) + DOY_W'(leap && (month > 4'd2));
		total = leap ? DOY_W'(366) : DOY_W'(365);
		remaining = (total >= doy) ? (total - doy) : '0;
	end
endmodule

// File: design/calendar_date_add_days.sv
// calendar date register with day addition
// req channel: op = 0 loads new_day/new_month/new_year (clamped to a valid
// range), op = 1 adds days_to_add to the stored date. one result per item on
// rsp: date, day of year, days left in the year, leap flag and overflow.
// one item is worked at a time; req.ready is high only while idle.
// a load runs a 10-step reduction of the year mod 25 on the shared
// subtractor, then the final step and the result register. an add
// walks the months on the same subtractor, crossing one month per cycle,
// then goes through the final step and the result register.
// a finished result sits in the output register; if rsp is stalled the next
// item is still taken and worked, and holds only at its final step until
// the output register frees up.
// reset sets the date to 1 january 2000 with no result pending.
module calendar_date_add_days (
	input  logic       clk,
	input  logic       arst_n,
	cdad_in_if.sink    req,
	cdad_out_if.source rsp
);
	import cdad_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MOD  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [DAY_W-1:0]   day_q;
	logic [MON_W-1:0]   mon_q;
	logic [YEAR_W-1:0]  year_q;
	logic [Y25_W-1:0]   y25_q;
	logic [SUM_W-1:0]   sum_q;
	logic [YEAR_W-1:0]  red_q;
	logic [KCNT_W-1:0]  k_q;
	logic               ovf_q;

	logic               out_valid_q;
	logic [DAY_W-1:0]   out_day_q;
	logic [MON_W-1:0]   out_month_q;
	logic [YEAR_W-1:0]  out_year_q;
	logic [DOY_W-1:0]   out_doy_q;
	logic [DOY_W-1:0]   out_rem_q;
	logic               out_leap_q;
	logic               out_ovf_q;

	logic               leap;
	logic [DAY_W-1:0]   len;
	logic [SUM_W-1:0]   sub_a, sub_b, diff;
	logic               borrow;
	logic               accept;
	logic               fin_load;
	logic [DOY_W-1:0]   doy, remaining;
	logic [DAY_W-1:0]   ld_day;
	logic [MON_W-1:0]   ld_mon;
	logic [YEAR_W-1:0]  ld_year;

	assign leap = leap_of(year_q, y25_q);
	assign len  = month_len(mon_q, leap);

	// shared subtractor: year reduction during loads, month walk during adds
	always_comb begin
		unique case (state_q)
			ST_MOD: begin
				sub_a = SUM_W'(red_q);
				sub_b = SUM_W'(MOD25) << k_q;
			end
			default: begin
				sub_a = sum_q;
				sub_b = SUM_W'(len);
			end
		endcase
		{borrow, diff} = {1'b0, sub_a} - {1'b0, sub_b};
	end

	always_comb begin
		ld_day = ((req.new_day == 6'd0) || (req.new_day > 6'd31)) ? DAY_W'(1) : req.new_day[DAY_W-1:0];
		ld_mon = ((req.new_month == 4'd0) || (req.new_month > 4'd12)) ? MON_W'(1) : req.new_month;
		if (req.new_year[LYEAR_W-1])
			ld_year = RESET_YEAR;
		else if (req.new_year > LYEAR_W'(YEAR_LIMIT))
			ld_year = YEAR_W'(YEAR_LIMIT);
		else
			ld_year = req.new_year[YEAR_W-1:0];
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	cdad_report u_report (
		.day       (day_q),
		.month     (mon_q),
		.leap      (leap),
		.doy       (doy),
		.remaining (remaining)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			day_q   <= DAY_W'(1);
			mon_q   <= MON_W'(1);
			year_q  <= RESET_YEAR;
			y25_q   <= RESET_Y25;
			ovf_q   <= 1'b0;
			sum_q   <= '0;
			red_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ovf_q <= 1'b0;
						if (!req.op) begin
							day_q   <= ld_day;
							mon_q   <= ld_mon;
							year_q  <= ld_year;
							red_q   <= ld_year;
							k_q     <= MOD_TOP;
							state_q <= ST_MOD;
						end else begin
							sum_q   <= SUM_W'(day_q) + SUM_W'(req.days_to_add & ADD_MASK);
							state_q <= ST_WALK;
						end
					end
				end
				ST_MOD: begin
					if (!borrow)
						red_q <= diff[YEAR_W-1:0];
					if (k_q == '0) begin
						y25_q   <= borrow ? red_q[Y25_W-1:0] : diff[Y25_W-1:0];
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q - KCNT_W'(1);
					end
				end
				ST_WALK: begin
					if (borrow || (diff == '0)) begin
						day_q   <= sum_q[DAY_W-1:0];
						state_q <= ST_FIN;
					end else begin
						sum_q <= diff;
						if (mon_q == MON_W'(12)) begin
							if (year_q >= YEAR_W'(YEAR_LIMIT)) begin
								// saturate at the last day of the largest year
								day_q   <= DAY_W'(31);
								year_q  <= YEAR_W'(YEAR_LIMIT);
								ovf_q   <= 1'b1;
								state_q <= ST_FIN;
							end else begin
								mon_q  <= MON_W'(1);
								year_q <= year_q + YEAR_W'(1);
								y25_q  <= (y25_q == MOD25 - Y25_W'(1)) ? '0 : y25_q + Y25_W'(1);
							end
						end else begin
							mon_q <= mon_q + MON_W'(1);
						end
					end
				end
				ST_FIN: begin
					if (fin_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_day_q   <= day_q;
			out_month_q <= mon_q;
			out_year_q  <= year_q;
			out_doy_q   <= doy;
			out_rem_q   <= remaining;
			out_leap_q  <= leap;
			out_ovf_q   <= ovf_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.out_day        = out_day_q;
	assign rsp.out_month      = out_month_q;
	assign rsp.out_year       = out_year_q;
	assign rsp.day_of_year    = out_doy_q;
	assign rsp.days_remaining = out_rem_q;
	assign rsp.is_leap        = out_leap_q;
	assign rsp.overflow       = out_ovf_q;

	a_y25_range: assert property (@(posedge clk) disable iff (!arst_n)
		y25_q < MOD25)
		else $error("year mod 25 tracker out of range");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("req ready right after a transfer");

	a_ovf_date: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.overflow |-> rsp.out_day == DAY_W'(31) && rsp.out_month == MON_W'(12)
			&& rsp.out_year == YEAR_W'(YEAR_LIMIT))
		else $error("overflow result not at the saturated date");

	a_leap_div4: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_leap |-> rsp.out_year[1:0] == 2'd0)
		else $error("leap flag on a year not divisible by 4");

	a_year_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.day_of_year + rsp.days_remaining) == (rsp.is_leap ? 366 : 365))
		else $error("day of year and days remaining do not add up to the year length");
endmodule

// File: tb/date_tb_pkg.sv
`timescale 1ns / 1ps
package date_tb_pkg;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_ADD  = 1'b1
	} date_op_t;

endpackage

// File: tb/date_checker.sv
`timescale 1ns / 1ps
module date_checker (
	input  logic clk,
	input  logic arst_n,
	cdad_in_if   req,
	cdad_out_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   result_count,
	output int   overflow_count
);
	import cdad_pkg::*;
	import date_tb_pkg::*;

	typedef struct packed {
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
		logic [DOY_W-1:0]  doy;
		logic [DOY_W-1:0]  left;
		logic              leap;
		logic              ovf;
	} date_result_t;

	int cur_day   = 1;
	int cur_month = 1;
	int cur_year  = 2000;

	date_result_t expected_dates[$];

	initial begin
		fail_count     = 0;
		pending        = 0;
		result_count   = 0;
		overflow_count = 0;
	end

	function automatic bit is_leap_year(int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int days_in_month(int m, int y);
		if (m == 2) begin
			return is_leap_year(y) ? 29 : 28;
		end
		if (m == 4 || m == 6 || m == 9 || m == 11) begin
			return 30;
		end
		return 31;
	endfunction

	// updates the held date and returns what the block must report for it
	function automatic date_result_t apply_request(logic op, logic [5:0] nd, logic [3:0] nm,
		logic signed [15:0] ny, logic [15:0] nadd);
		date_result_t r;
		int walk;
		int m;
		int y;
		int doy;
		int year_len;
		bit ovf;
		ovf = 1'b0;
		if (op == OP_LOAD) begin
			cur_day   = (nd == 0 || nd > 31) ? 1 : int'(nd);
			cur_month = (nm == 0 || nm > 12) ? 1 : int'(nm);
			if (ny < 0) begin
				cur_year = 2000;
			end else if (int'(ny) > YEAR_LIMIT) begin
				cur_year = YEAR_LIMIT;
			end else begin
				cur_year = int'(ny);
			end
		end else begin
			walk = cur_day + int'(nadd & ADD_MASK);
			m = cur_month;
			y = cur_year;
			// one month per step; an oversized loaded day rolls forward too
			while (!ovf && walk > days_in_month(m, y)) begin
				walk -= days_in_month(m, y);
				m++;
				if (m > 12) begin
					m = 1;
					if (y >= YEAR_LIMIT) begin
						m = 12;
						walk = 31;
						y = YEAR_LIMIT;
						ovf = 1'b1;
					end else begin
						y++;
					end
				end
			end
			cur_day = walk;
			cur_month = m;
			cur_year = y;
		end
		doy = cur_day;
		for (int k = 1; k < cur_month; k++) begin
			doy += days_in_month(k, cur_year);
		end
		year_len = is_leap_year(cur_year) ? 366 : 365;
		r.day   = DAY_W'(cur_day);
		r.month = MON_W'(cur_month);
		r.year  = YEAR_W'(cur_year);
		r.doy   = DOY_W'(doy);
		r.left  = DOY_W'((year_len >= doy) ? year_len - doy : 0);
		r.leap  = is_leap_year(cur_year);
		r.ovf   = ovf;
		return r;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		date_result_t got;
		date_result_t want;
		if (arst_n) begin
			// results first, so a result can never match the item taken at the same edge
			if (rsp.valid && rsp.ready) begin
				got = '{day: rsp.out_day, month: rsp.out_month, year: rsp.out_year,
					doy: rsp.day_of_year, left: rsp.days_remaining, leap: rsp.is_leap,
					ovf: rsp.overflow};
				result_count++;
				if (expected_dates.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, got %0d/%0d/%0d", $time,
						got.day, got.month, got.year);
				end else begin
					want = expected_dates.pop_front();
					check_field("out_day", want.day, got.day);
					check_field("out_month", want.month, got.month);
					check_field("out_year", want.year, got.year);
					check_field("day_of_year", want.doy, got.doy);
					check_field("days_remaining", want.left, got.left);
					check_field("is_leap", want.leap, got.leap);
					check_field("overflow", want.ovf, got.ovf);
				end
			end
			if (req.valid && req.ready) begin
				want = apply_request(req.op, req.new_day, req.new_month, req.new_year,
					req.days_to_add);
				if (want.ovf) begin
					overflow_count++;
				end
				expected_dates.push_back(want);
			end
			pending = expected_dates.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import cdad_pkg::*;
	import date_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1800;
	localparam int HOLD_AT      = 600;
	localparam int DRAIN_AT     = 1200;
	localparam int QUIET_AT     = RANDOM_ITEMS - 200;
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 64;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int fail_count;
	int pending;
	int result_count;
	int overflow_count;
	int load_count = 0;
	int add_count  = 0;
	bit quiet        = 1'b0;
	bit hold_request = 1'b0;
	bit tx_gappy     = 1'b1;

	cdad_in_if  req();
	cdad_out_if rsp();

	calendar_date_add_days dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	date_checker u_date_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.fail_count     (fail_count),
		.pending        (pending),
		.result_count   (result_count),
		.overflow_count (overflow_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_item(date_op_t op, logic [5:0] nd, logic [3:0] nm, logic [15:0] ny,
		logic [15:0] nadd);
		@(negedge clk);
		req.valid       <= 1'b1;
		req.op          <= op;
		req.new_day     <= nd;
		req.new_month   <= nm;
		req.new_year    <= ny;
		req.days_to_add <= nadd;
		do @(posedge clk); while (!req.ready);
		if (op == OP_LOAD) begin
			load_count++;
		end else begin
			add_count++;
		end
	endtask

	task automatic idle_sender(int cycles);
		@(negedge clk);
		req.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// receiver: short random stalls, calm stretches, and one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		bit rx_gappy;
		stall_left = 0;
		hold_left  = 0;
		rx_gappy   = 1'b1;
		rsp.ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left = LONG_HOLD;
				hold_request = 1'b0;
			end
			if ($urandom_range(0, 149) == 0) begin
				rx_gappy = !rx_gappy;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if (!quiet && rx_gappy && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 4);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
		$display("tb failed");
		$finish;
	end

	initial begin
		int pick;
		logic [15:0] amount;
		req.valid       = 1'b0;
		req.op          = OP_LOAD;
		req.new_day     = '0;
		req.new_month   = '0;
		req.new_year    = '0;
		req.days_to_add = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: clamps, leap rules, short-month rollover, saturation
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd0);
		send_item(OP_LOAD, 6'd0, 4'd0, 16'hFFFF, 16'hFFFF);
		send_item(OP_LOAD, 6'd63, 4'd15, 16'h8000, 16'd0);
		send_item(OP_LOAD, 6'd32, 4'd13, 16'h7FFF, 16'd0);
		send_item(OP_LOAD, 6'd31, 4'd12, 16'd10000, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd1);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd0);
		send_item(OP_LOAD, 6'd31, 4'd2, 16'd2001, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd0);
		send_item(OP_LOAD, 6'd29, 4'd2, 16'd1900, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd0);
		send_item(OP_LOAD, 6'd29, 4'd2, 16'd2000, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd0);
		send_item(OP_LOAD, 6'd1, 4'd1, 16'd0, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd59);
		send_item(OP_LOAD, 6'd31, 4'd12, 16'd2023, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd1);
		send_item(OP_LOAD, 6'd1, 4'd1, 16'd0, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'hFFFF);
		send_item(OP_LOAD, 6'd1, 4'd1, 16'd9990, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'hFFFF);
		send_item(OP_LOAD, 6'd31, 4'd4, 16'd2024, 16'd0);
		send_item(OP_LOAD, 6'd15, 4'd6, 16'd2400, 16'd0);
		send_item(OP_ADD, 6'd0, 4'd0, 16'd0, 16'd365);
		send_item(OP_LOAD, 6'd31, 4'd12, 16'd2000, 16'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT) begin
				hold_request = 1'b1;
			end
			if (i == DRAIN_AT) begin
				@(negedge clk);
				req.valid <= 1'b0;
				wait (pending == 0);
			end
			if (i == QUIET_AT) begin
				quiet = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				send_item(OP_LOAD, 6'($urandom_range(1, 31)), 4'($urandom_range(1, 12)),
					16'($urandom_range(0, YEAR_LIMIT)), 16'($urandom));
			end else if (pick < 25) begin
				// near the top year so later adds run into saturation
				send_item(OP_LOAD, 6'($urandom_range(1, 31)), 4'($urandom_range(1, 12)),
					16'($urandom_range(YEAR_LIMIT - 5, YEAR_LIMIT)), 16'($urandom));
			end else if (pick < 31) begin
				send_item(OP_LOAD, 6'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					amount = 16'($urandom_range(0, 40));
				end else if (pick < 80) begin
					amount = 16'($urandom_range(0, 400));
				end else if (pick < 96) begin
					amount = 16'($urandom_range(0, 4000));
				end else begin
					amount = 16'($urandom);
				end
				send_item(OP_ADD, 6'($urandom), 4'($urandom), 16'($urandom), amount);
			end
			if (!quiet && tx_gappy && $urandom_range(0, 3) == 0) begin
				idle_sender($urandom_range(1, 5));
			end
			if ($urandom_range(0, 149) == 0) begin
				tx_gappy = !tx_gappy;
			end
		end

		@(negedge clk);
		req.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d loads and %0d adds, %0d results checked, %0d saturated adds",
			load_count, add_count, result_count, overflow_count);
		$display("with a %0d-cycle output hold-off and a full drain partway through",
			LONG_HOLD);
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
